// File: design/gqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_pkg
// Shared widths, register codes, request opcodes and record types of the
// grouped-query last-query token scorer.
// ----------------------------------------------------------------------------
package gqa_pkg;

    localparam int HEAD_W     = 7;
    localparam int DIM_W      = 7;
    localparam int TOKEN_W    = 16;
    localparam int VALUE_W    = 16;
    localparam int SUM_W      = 20;
    localparam int PROD_W     = SUM_W + VALUE_W;
    localparam int ACC_W      = 46;
    localparam int SCALE_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int SPROD_W    = ACC_W + SCALE_W + 1;
    localparam int SCORE_W    = 48;
    localparam int KH_W       = 4;
    localparam int HD_W       = 8;
    localparam int KV_W       = 4;
    localparam int GRP_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic REQ_KEY = 1'b1;

    localparam logic [HD_W-1:0]    HEAD_DIM_RST    = 8'd128;
    localparam logic [KV_W-1:0]    KV_HEADS_RST    = 4'd8;
    localparam logic [GRP_W-1:0]   GROUP_SIZE_RST  = 5'd4;
    localparam logic [SCALE_W-1:0] SCORE_SCALE_RST = 16'd5793;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAD_DIM    = 2'd0,
        CFG_KV_HEADS    = 2'd1,
        CFG_GROUP_SIZE  = 2'd2,
        CFG_SCORE_SCALE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [HD_W-1:0]    head_dim;
        logic [KV_W-1:0]    kv_heads;
        logic [GRP_W-1:0]   group_size;
        logic [SCALE_W-1:0] score_scale;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_QSET = 2'd0,
        OP_QADD = 2'd1,
        OP_KEY  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic [KH_W-1:0]            kh;
        logic [DIM_W-1:0]           dim;
        logic                       last;
        logic [TOKEN_W-1:0]         token;
        logic signed [VALUE_W-1:0]  value;
    } t_entry;

endpackage

// File: design/gqa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_req_if
// Request channel: one query or key element per transfer.
// ----------------------------------------------------------------------------
interface gqa_req_if import gqa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [HEAD_W-1:0]         head;
    logic [DIM_W-1:0]          dim;
    logic [TOKEN_W-1:0]        token;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, req_type, head, dim, token, value, input ready);
    modport sink   (input valid, req_type, head, dim, token, value, output ready);
endinterface

// File: design/gqa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_rsp_if
// Result channel: one token score per transfer.
// ----------------------------------------------------------------------------
interface gqa_rsp_if import gqa_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [TOKEN_W-1:0]        token_index;
    logic signed [SCORE_W-1:0] score;

    modport source (output valid, token_index, score, input ready);
    modport sink   (input valid, token_index, score, output ready);
endinterface

// File: design/gqa_last_query_token_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_last_query_token_scorer
// Scores prompt tokens by their raw attention affinity to the last query row
// under grouped-query attention.
// ----------------------------------------------------------------------------
// Send the last query row first, one element per request, then the key
// elements. Key requests are taken one per cycle for as long as the result
// side keeps up; the multiply-accumulate path and the group-sum store, with
// one read and one write port, each handle one element per cycle. A query
// request occupies the input while the bit-serial divider maps a query head
// to its KV group (one quotient bit per cycle over the 7-bit head) and until
// its operation enters the queue. Once its last key element is accepted, the
// score of a token passes the queue and the read, accumulate, scale and output registers.
// The group-sum store is not cleared after reset: a key or a later query head
// must not read an entry that no first query head of its group has written.
// Change the configuration registers only while no request is in flight.
// ----------------------------------------------------------------------------
module gqa_last_query_token_scorer import gqa_pkg::*; #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int MAX_KV_HEADS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gqa_req_if.sink               i_req,
    gqa_rsp_if.source             o_rsp
);

    t_cfg   r_cfg;
    t_cfg   eff;
    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.head_dim    <= HEAD_DIM_RST;
            r_cfg.kv_heads    <= KV_HEADS_RST;
            r_cfg.group_size  <= GROUP_SIZE_RST;
            r_cfg.score_scale <= SCORE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HEAD_DIM:    r_cfg.head_dim    <= i_cfg_data[HD_W-1:0];
                CFG_KV_HEADS:    r_cfg.kv_heads    <= i_cfg_data[KV_W-1:0];
                CFG_GROUP_SIZE:  r_cfg.group_size  <= i_cfg_data[GRP_W-1:0];
                CFG_SCORE_SCALE: r_cfg.score_scale <= i_cfg_data[SCALE_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // clamp sizes to what the store holds; a group size of zero acts as one
    always_comb begin
        eff = r_cfg;
        if (int'(r_cfg.head_dim) > MAX_HEAD_DIM) eff.head_dim = HD_W'(MAX_HEAD_DIM);
        if (int'(r_cfg.kv_heads) > MAX_KV_HEADS) eff.kv_heads = KV_W'(MAX_KV_HEADS);
        if (r_cfg.group_size == '0)              eff.group_size = GRP_W'(1);
    end

    gqa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_eff        (eff),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    gqa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    gqa_back #(
        .MAX_HEAD_DIM (MAX_HEAD_DIM),
        .MAX_KV_HEADS (MAX_KV_HEADS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (eff.score_scale),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// File: design/gqa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_front
// Accepts requests, drops out-of-range ones, maps query heads to their KV
// group with a bit-serial divider and pushes operations to the queue.
// ----------------------------------------------------------------------------
module gqa_front import gqa_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_eff,
    gqa_req_if.sink       i_req,
    output logic          o_push_valid,
    output t_entry        o_push_entry,
    input  logic          i_push_ready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_ISSUE  = 3'b100
    } t_front_state;

    t_front_state              r_state, n_state;
    logic [DIM_W-1:0]          r_dim;
    logic signed [VALUE_W-1:0] r_value;
    logic [HEAD_W-1:0]         r_dvd;
    logic [HEAD_W-1:0]         r_quo;
    logic [GRP_W-1:0]          r_rem;
    logic [2:0]                r_cnt;

    logic              accept;
    logic [DIM_W:0]    dim_ext;
    logic              dim_ok;
    logic              kv_ok;
    logic              head_ok;
    logic              key_last;
    logic              key_push;
    logic              query_start;
    logic [GRP_W:0]    trial;
    logic [GRP_W:0]    gdiv;
    logic              ge;
    logic              q_ok;

    assign dim_ext  = {1'b0, i_req.dim};
    assign dim_ok   = dim_ext < i_eff.head_dim;
    assign kv_ok    = i_eff.kv_heads != '0;
    assign head_ok  = i_req.head < HEAD_W'(i_eff.kv_heads);
    assign key_last = (i_req.head == HEAD_W'(i_eff.kv_heads - 1'b1))
                   && (dim_ext == i_eff.head_dim - 1'b1);

    assign i_req.ready = (r_state == ST_IDLE) && i_push_ready;
    assign accept      = i_req.valid && i_req.ready;
    assign key_push    = accept && (i_req.req_type == REQ_KEY) && dim_ok && kv_ok && head_ok;
    assign query_start = accept && (i_req.req_type != REQ_KEY) && dim_ok && kv_ok;

    // one quotient bit per cycle: restoring division of head by group_size
    assign gdiv  = {1'b0, i_eff.group_size};
    assign trial = {r_rem, r_dvd[HEAD_W-1]};
    assign ge    = trial >= gdiv;
    assign q_ok  = r_quo < HEAD_W'(i_eff.kv_heads);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (query_start) n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (r_cnt == 3'(HEAD_W - 1)) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (!q_ok || i_push_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_start) begin
            r_dim   <= i_req.dim;
            r_value <= i_req.value;
            r_dvd   <= i_req.head;
            r_quo   <= '0;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_state == ST_DIVIDE) begin
            r_dvd <= {r_dvd[HEAD_W-2:0], 1'b0};
            r_quo <= {r_quo[HEAD_W-2:0], ge};
            r_rem <= ge ? GRP_W'(trial - gdiv) : GRP_W'(trial);
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_comb begin
        o_push_valid = 1'b0;
        o_push_entry = '0;
        if (r_state == ST_ISSUE) begin
            o_push_valid       = q_ok;
            // the first head of a group restarts the sum
            o_push_entry.op    = (r_rem == '0) ? OP_QSET : OP_QADD;
            o_push_entry.kh    = KH_W'(r_quo);
            o_push_entry.dim   = r_dim;
            o_push_entry.value = r_value;
        end else begin
            o_push_valid       = key_push;
            o_push_entry.op    = OP_KEY;
            o_push_entry.kh    = KH_W'(i_req.head);
            o_push_entry.dim   = i_req.dim;
            o_push_entry.last  = key_last;
            o_push_entry.token = i_req.token;
            o_push_entry.value = i_req.value;
        end
    end

endmodule

// File: design/gqa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_queue
// Short FIFO of operations between the front and back sections.
// ----------------------------------------------------------------------------
module gqa_queue import gqa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    input  t_entry i_push_entry,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_entry o_pop_entry,
    input  logic   i_pop_ready
);

    t_entry            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wr_ptr] <= i_push_entry;
    end

endmodule

// File: design/gqa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_back
// Executes queued operations: group-sum store updates, key multiply-accumulate
// and the final score scaling, with a registered result stage.
// ----------------------------------------------------------------------------
module gqa_back import gqa_pkg::*; #(
    parameter int MAX_HEAD_DIM = 128,
    parameter int MAX_KV_HEADS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SCALE_W-1:0] i_scale,
    input  logic               i_pop_valid,
    input  t_entry             i_pop_entry,
    output logic               o_pop_ready,
    gqa_rsp_if.source          o_rsp
);

    localparam int DEPTH = MAX_KV_HEADS * MAX_HEAD_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [SUM_W-1:0] mem [DEPTH];

    logic                      adv;
    logic                      pop;
    logic [AW-1:0]             addr_a;

    // read stage
    logic                      r_b_valid;
    t_entry                    r_b_entry;
    logic [AW-1:0]             r_b_addr;
    logic [SUM_W-1:0]          r_rd;
    logic                      r_fwd;
    logic [SUM_W-1:0]          r_fwd_data;
    logic signed [SUM_W-1:0]   q_old;
    logic signed [SUM_W-1:0]   val_ext;
    logic [SUM_W-1:0]          w_data;
    logic                      w_en;
    logic signed [PROD_W-1:0]  prod_b;

    // accumulate stage
    logic                      r_c_valid;
    logic signed [PROD_W-1:0]  r_c_prod;
    logic                      r_c_last;
    logic [TOKEN_W-1:0]        r_c_token;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ACC_W-1:0]   n_acc;

    // scale stages
    logic                      r_d_valid;
    logic signed [ACC_W-1:0]   r_d_acc;
    logic [TOKEN_W-1:0]        r_d_token;
    logic                      r_e_valid;
    logic signed [SPROD_W-1:0] r_e_prod;
    logic [TOKEN_W-1:0]        r_e_token;

    logic                      r_out_valid;
    logic [TOKEN_W-1:0]        r_out_token;
    logic signed [SCORE_W-1:0] r_out_score;

    // the whole pipeline holds while a result waits at the output
    assign adv         = !r_out_valid || o_rsp.ready;
    assign o_pop_ready = adv;
    assign pop         = i_pop_valid && adv;
    assign addr_a      = AW'(i_pop_entry.kh * MAX_HEAD_DIM) + AW'(i_pop_entry.dim);

    assign q_old   = r_fwd ? r_fwd_data : r_rd;
    assign val_ext = SUM_W'(r_b_entry.value);
    assign prod_b  = q_old * r_b_entry.value;

    always_comb begin
        w_en   = 1'b0;
        w_data = q_old + val_ext;
        case (r_b_entry.op)
            OP_QSET: begin
                w_en   = r_b_valid;
                w_data = val_ext;
            end
            OP_QADD: begin
                w_en   = r_b_valid;
            end
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (w_en) mem[r_b_addr] <= w_data;
            if (pop)  r_rd <= mem[addr_a];
        end
    end

    assign n_acc = r_acc + ACC_W'(r_c_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_fwd       <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (adv) begin
            r_b_valid   <= pop;
            // bypass a store write that the next read of the same entry misses
            r_fwd       <= pop && w_en && (r_b_addr == addr_a);
            r_c_valid   <= r_b_valid && (r_b_entry.op == OP_KEY);
            r_d_valid   <= r_c_valid && r_c_last;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
            if (r_c_valid) begin
                r_acc <= r_c_last ? '0 : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_entry   <= i_pop_entry;
            r_b_addr    <= addr_a;
            r_fwd_data  <= w_data;
            r_c_prod    <= prod_b;
            r_c_last    <= r_b_entry.last;
            r_c_token   <= r_b_entry.token;
            r_d_acc     <= n_acc;
            r_d_token   <= r_c_token;
            r_e_prod    <= r_d_acc * $signed({1'b0, i_scale});
            r_e_token   <= r_d_token;
            r_out_token <= r_e_token;
            r_out_score <= SCORE_W'(r_e_prod >>> FRAC_W);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.token_index = r_out_token;
    assign o_rsp.score       = r_out_score;

endmodule

// File: design/gqa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_checker
// Port-level checks on the token scorer: reset, result hold and result count.
// ----------------------------------------------------------------------------
module gqa_checker import gqa_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [TOKEN_W-1:0]        i_out_token,
    input logic signed [SCORE_W-1:0] i_out_score
);

    logic [31:0] r_in_cnt;
    logic [31:0] r_out_cnt;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (in_acc)  r_in_cnt  <= r_in_cnt + 32'd1;
            if (out_acc) r_out_cnt <= r_out_cnt + 32'd1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_token) && $stable(i_out_score))
        else $error("stalled result changed");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_out_cnt < r_in_cnt)
        else $error("more results than requests");

endmodule

bind gqa_last_query_token_scorer gqa_checker u_gqa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_token (o_rsp.token_index),
    .i_out_score (o_rsp.score)
);
